FILE: hw/rtl/iiat_pkg.sv
`timescale 1ns / 1ps
package iiat_pkg;

    // image store geometry
    localparam int MAX_WIDTH   = 128;
    localparam int MAX_HEIGHT  = 128;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // field and register widths
    localparam int CRD_W   = 7;
    localparam int PIX_W   = 8;
    localparam int CFG_W   = 8;
    localparam int IDX_W   = 2;
    localparam int PCT_W   = 7;
    localparam int RSUM_W  = 15;
    localparam int INTEG_W = 22;

    // datapath widths
    localparam int ACC_W   = INTEG_W + 3;
    localparam int SUM_W   = ACC_W - 1;
    localparam int CNT_W   = 2 * CRD_W;
    localparam int CUR_W   = 15;
    localparam int LHS_W   = CNT_W + CUR_W;
    localparam int RHS_W   = SUM_W + PCT_W;
    localparam int MUL_A_W = SUM_W;
    localparam int MUL_B_W = CUR_W;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // register reset values and scale constants
    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = 8'd128;
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = 8'd128;
    localparam logic [CFG_W-1:0] RST_WINDOW_SIZE  = 8'd16;
    localparam logic [PCT_W-1:0] RST_THRESHOLD    = 7'd15;
    localparam logic [PCT_W-1:0] PCT_FULL         = 7'd100;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CRD_W-1:0]  t_crd;

    typedef enum logic [IDX_W-1:0] {
        CFG_IMAGE_WIDTH,
        CFG_IMAGE_HEIGHT,
        CFG_WINDOW_SIZE,
        CFG_THRESHOLD
    } t_cfg_reg;

    // microprogram steps
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_LD_RD,
        ST_LD_WR,
        ST_Q0,
        ST_Q1,
        ST_Q2,
        ST_Q3,
        ST_Q4,
        ST_Q5,
        ST_Q6,
        ST_QZERO
    } t_step;

    // integral store address select
    typedef enum logic [2:0] {
        ASEL_CUR,
        ASEL_UP,
        ASEL_X2Y2,
        ASEL_X2Y1M,
        ASEL_X1MY2,
        ASEL_X1MY1M
    } t_asel;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_CLR,
        ACC_ADD,
        ACC_SUB
    } t_acc_op;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_CNT,
        MUL_CUR,
        MUL_LHS,
        MUL_RHS
    } t_mul_op;

    typedef enum logic [1:0] {
        OUT_NONE,
        OUT_CMP,
        OUT_ZERO
    } t_out_op;

    typedef enum logic [2:0] {
        JMP_NEXT,
        JMP_GOTO,
        JMP_WAIT_IN,
        JMP_DISPATCH,
        JMP_WAIT_OUT
    } t_jump;

    // one control word
    typedef struct packed {
        logic    in_ready;
        logic    setup;
        logic    rsum_upd;
        logic    int_we;
        logic    pix_we;
        logic    cur_ld;
        t_asel   addr_sel;
        t_acc_op acc_op;
        t_mul_op mul_op;
        t_out_op out_op;
        t_jump   jump;
        t_step   target;
    } t_ctrl;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic accept;
        logic is_load;
        logic in_image;
        logic out_free;
    } t_stat;

    function automatic t_addr addr_of(input t_crd x, input t_crd y);
        return ADDR_W'(y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x);
    endfunction

    // microprogram rom
    function automatic t_ctrl ucode(input t_step s);
        t_ctrl c;
        c = '0;
        c.target = ST_IDLE;
        unique case (s)
            ST_IDLE: begin
                c.in_ready = 1'b1;
                c.jump     = JMP_WAIT_IN;
            end
            ST_SETUP: begin
                c.setup = 1'b1;
                c.jump  = JMP_DISPATCH;
            end
            ST_LD_RD: begin
                c.addr_sel = ASEL_UP;
                c.rsum_upd = 1'b1;
                c.jump     = JMP_NEXT;
            end
            ST_LD_WR: begin
                c.addr_sel = ASEL_CUR;
                c.int_we   = 1'b1;
                c.pix_we   = 1'b1;
                c.jump     = JMP_GOTO;
                c.target   = ST_IDLE;
            end
            ST_Q0: begin
                c.addr_sel = ASEL_X2Y2;
                c.acc_op   = ACC_CLR;
                c.jump     = JMP_NEXT;
            end
            ST_Q1: begin
                c.addr_sel = ASEL_X2Y1M;
                c.acc_op   = ACC_ADD;
                c.cur_ld   = 1'b1;
                c.jump     = JMP_NEXT;
            end
            ST_Q2: begin
                c.addr_sel = ASEL_X1MY2;
                c.acc_op   = ACC_SUB;
                c.mul_op   = MUL_CNT;
                c.jump     = JMP_NEXT;
            end
            ST_Q3: begin
                c.addr_sel = ASEL_X1MY1M;
                c.acc_op   = ACC_SUB;
                c.mul_op   = MUL_CUR;
                c.jump     = JMP_NEXT;
            end
            ST_Q4: begin
                c.acc_op = ACC_ADD;
                c.mul_op = MUL_LHS;
                c.jump   = JMP_NEXT;
            end
            ST_Q5: begin
                c.mul_op = MUL_RHS;
                c.jump   = JMP_NEXT;
            end
            ST_Q6: begin
                c.out_op = OUT_CMP;
                c.jump   = JMP_WAIT_OUT;
                c.target = ST_IDLE;
            end
            ST_QZERO: begin
                c.out_op = OUT_ZERO;
                c.jump   = JMP_WAIT_OUT;
                c.target = ST_IDLE;
            end
            default: begin
                c.jump   = JMP_GOTO;
                c.target = ST_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage

FILE: hw/rtl/iiat_stream_if.sv
`timescale 1ns / 1ps

// pixel command channel
interface iiat_pix_if;
    import iiat_pkg::*;
    logic             valid;
    logic             ready;
    logic             cmd;
    logic [CRD_W-1:0] pixel_x;
    logic [CRD_W-1:0] pixel_y;
    logic [PIX_W-1:0] pixel_value;

    modport source (output valid, cmd, pixel_x, pixel_y, pixel_value, input ready);
    modport sink   (input valid, cmd, pixel_x, pixel_y, pixel_value, output ready);
endinterface

// binarized result channel
interface iiat_res_if;
    logic valid;
    logic ready;
    logic is_bright;

    modport source (output valid, is_bright, input ready);
    modport sink   (input valid, is_bright, output ready);
endinterface

FILE: hw/rtl/integral_image_adaptive_threshold.sv
// one word at a time: a load runs setup, read and write steps; outside the image, setup only
// query result valid after setup and steps Q0-Q6 (QZERO when outside), ready again with it
// the query length is set by four reads of the single-port integral memory and the
// shared multiplier steps of the microprogram; a waiting result holds only the last step
// synchronous active-low reset returns the sequencer to idle, clears the output word,
// the row running sum and restores the register defaults; pixel and integral memories keep data
`timescale 1ns / 1ps
module integral_image_adaptive_threshold (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [iiat_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [iiat_pkg::CFG_W-1:0]  i_cfg_data,
    iiat_pix_if.sink                    i_pix,
    iiat_res_if.source                  o_res
);
    import iiat_pkg::*;

    t_ctrl ctrl;
    t_stat stat;

    // microprogram sequencer
    iiat_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    // datapath with stores and shared multiplier
    iiat_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .o_stat      (stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pix       (i_pix),
        .o_res       (o_res)
    );

endmodule

FILE: hw/rtl/iiat_ram.sv
`timescale 1ns / 1ps
module iiat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/iiat_sequencer.sv
`timescale 1ns / 1ps
module iiat_sequencer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  iiat_pkg::t_stat i_stat,
    output iiat_pkg::t_ctrl o_ctrl
);
    import iiat_pkg::*;

    t_step r_step;
    t_step n_step;

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    // next step from the jump field
    always_comb begin
        n_step = r_step;
        unique case (o_ctrl.jump)
            JMP_NEXT: begin
                n_step = t_step'(r_step + 4'd1);
            end
            JMP_GOTO: begin
                n_step = o_ctrl.target;
            end
            JMP_WAIT_IN: begin
                if (i_stat.accept) begin
                    n_step = t_step'(r_step + 4'd1);
                end
            end
            JMP_DISPATCH: begin
                if (!i_stat.in_image) begin
                    n_step = i_stat.is_load ? ST_IDLE : ST_QZERO;
                end else begin
                    n_step = i_stat.is_load ? ST_LD_RD : ST_Q0;
                end
            end
            JMP_WAIT_OUT: begin
                if (i_stat.out_free) begin
                    n_step = o_ctrl.target;
                end
            end
            default: begin
                n_step = ST_IDLE;
            end
        endcase
    end

    // control word lookup
    always_comb begin
        o_ctrl = ucode(r_step);
    end

endmodule

FILE: hw/rtl/iiat_datapath.sv
`timescale 1ns / 1ps
module iiat_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  iiat_pkg::t_ctrl             i_ctrl,
    output iiat_pkg::t_stat             o_stat,
    input  logic                        i_cfg_we,
    input  logic [iiat_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [iiat_pkg::CFG_W-1:0]  i_cfg_data,
    iiat_pix_if.sink                    i_pix,
    iiat_res_if.source                  o_res
);
    import iiat_pkg::*;

    // configuration registers
    logic [CFG_W-1:0] r_img_w;
    logic [CFG_W-1:0] r_img_h;
    logic [CFG_W-1:0] r_win;
    logic [PCT_W-1:0] r_thr;

    // latched word and query geometry
    logic             r_cmd;
    t_crd             r_x;
    t_crd             r_y;
    logic [PIX_W-1:0] r_v;
    t_crd             r_x1;
    t_crd             r_x2;
    t_crd             r_y1;
    t_crd             r_y2;

    logic [RSUM_W-1:0] r_rsum;
    logic [ACC_W-1:0]  r_acc;
    logic [PIX_W-1:0]  r_cur;
    logic [CNT_W-1:0]  r_cnt;
    logic [CUR_W-1:0]  r_cur100;
    logic [LHS_W-1:0]  r_lhs;
    logic [RHS_W-1:0]  r_rhs;
    logic              r_rd_zero;
    logic              r_out_valid;
    logic              r_out_bright;

    logic             accept;
    logic             out_free;
    logic [CFG_W-1:0] eff_w;
    logic [CFG_W-1:0] eff_h;
    t_crd             w_max;
    t_crd             h_max;
    t_crd             half;
    logic             in_image;
    logic [CFG_W-1:0] x_hi;
    logic [CFG_W-1:0] y_hi;
    t_crd             x1;
    t_crd             x2;
    t_crd             y1;
    t_crd             y2;
    logic [PCT_W-1:0] keep_pct;
    t_crd             dx;
    t_crd             dy;

    t_addr                int_addr;
    logic                 rd_zero;
    logic [INTEG_W-1:0]   int_rdata;
    logic [INTEG_W-1:0]   int_masked;
    logic [INTEG_W-1:0]   int_wdata;
    logic [PIX_W-1:0]     pix_rdata;
    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic [MUL_P_W-1:0]   mul_p;
    logic                 bright;

    // handshake and status, no word taken while in reset
    assign accept      = i_pix.valid & i_ctrl.in_ready & i_rst_n;
    assign i_pix.ready = i_ctrl.in_ready & i_rst_n;
    assign out_free    = !r_out_valid || o_res.ready;
    assign o_res.valid     = r_out_valid;
    assign o_res.is_bright = r_out_bright;

    assign o_stat.accept   = accept;
    assign o_stat.is_load  = !r_cmd;
    assign o_stat.in_image = in_image;
    assign o_stat.out_free = out_free;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= RST_IMAGE_WIDTH;
            r_img_h <= RST_IMAGE_HEIGHT;
            r_win   <= RST_WINDOW_SIZE;
            r_thr   <= RST_THRESHOLD;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_IMAGE_WIDTH:  r_img_w <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_img_h <= i_cfg_data;
                CFG_WINDOW_SIZE:  r_win   <= i_cfg_data;
                CFG_THRESHOLD:    r_thr   <= i_cfg_data[PCT_W-1:0];
                default: ;
            endcase
        end
    end

    // size in use, limited to one through the store size
    always_comb begin
        eff_w = r_img_w;
        if (r_img_w == '0) begin
            eff_w = CFG_W'(1);
        end else if (r_img_w > CFG_W'(MAX_WIDTH)) begin
            eff_w = CFG_W'(MAX_WIDTH);
        end
        eff_h = r_img_h;
        if (r_img_h == '0) begin
            eff_h = CFG_W'(1);
        end else if (r_img_h > CFG_W'(MAX_HEIGHT)) begin
            eff_h = CFG_W'(MAX_HEIGHT);
        end
    end

    // window corners, clamped to the image
    always_comb begin
        w_max    = CRD_W'(eff_w - CFG_W'(1));
        h_max    = CRD_W'(eff_h - CFG_W'(1));
        half     = r_win[CFG_W-1:1];
        in_image = ({1'b0, r_x} < eff_w) && ({1'b0, r_y} < eff_h);
        x_hi     = {1'b0, r_x} + {1'b0, half};
        y_hi     = {1'b0, r_y} + {1'b0, half};
        x1       = (r_x > half) ? r_x - half : '0;
        y1       = (r_y > half) ? r_y - half : '0;
        x2       = (x_hi > {1'b0, w_max}) ? w_max : x_hi[CRD_W-1:0];
        y2       = (y_hi > {1'b0, h_max}) ? h_max : y_hi[CRD_W-1:0];
        if (x1 > w_max) begin
            x1 = w_max;
        end
        if (y1 > h_max) begin
            y1 = h_max;
        end
    end

    assign keep_pct = (r_thr > PCT_FULL) ? '0 : PCT_FULL - r_thr;
    assign dx       = r_x2 - r_x1;
    assign dy       = r_y2 - r_y1;

    // input latch and geometry registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_pix.cmd;
            r_x   <= i_pix.pixel_x;
            r_y   <= i_pix.pixel_y;
            r_v   <= i_pix.pixel_value;
        end
        if (i_ctrl.setup) begin
            r_x1 <= x1;
            r_x2 <= x2;
            r_y1 <= y1;
            r_y2 <= y2;
        end
    end

    // integral store address and before-image flag
    always_comb begin
        int_addr = addr_of(r_x, r_y);
        rd_zero  = 1'b0;
        unique case (i_ctrl.addr_sel)
            ASEL_CUR: begin
                int_addr = addr_of(r_x, r_y);
            end
            ASEL_UP: begin
                int_addr = addr_of(r_x, r_y - CRD_W'(1));
                rd_zero  = (r_y == '0);
            end
            ASEL_X2Y2: begin
                int_addr = addr_of(r_x2, r_y2);
            end
            ASEL_X2Y1M: begin
                int_addr = addr_of(r_x2, r_y1 - CRD_W'(1));
                rd_zero  = (r_y1 == '0);
            end
            ASEL_X1MY2: begin
                int_addr = addr_of(r_x1 - CRD_W'(1), r_y2);
                rd_zero  = (r_x1 == '0);
            end
            ASEL_X1MY1M: begin
                int_addr = addr_of(r_x1 - CRD_W'(1), r_y1 - CRD_W'(1));
                rd_zero  = (r_x1 == '0) || (r_y1 == '0);
            end
            default: ;
        endcase
    end

    assign int_masked = r_rd_zero ? '0 : int_rdata;
    assign int_wdata  = INTEG_W'(r_rsum) + int_masked;

    iiat_ram #(
        .WIDTH (INTEG_W),
        .DEPTH (STORE_DEPTH)
    ) u_integral_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctrl.int_we),
        .i_addr  (int_addr),
        .i_wdata (int_wdata),
        .o_rdata (int_rdata)
    );

    iiat_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_pixel_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctrl.pix_we),
        .i_addr  (addr_of(r_x, r_y)),
        .i_wdata (r_v),
        .o_rdata (pix_rdata)
    );

    // row running sum, cleared at column zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsum <= '0;
        end else if (i_ctrl.rsum_upd) begin
            r_rsum <= ((r_x == '0) ? '0 : r_rsum) + RSUM_W'(r_v);
        end
    end

    // window sum accumulator and pixel capture
    always_ff @(posedge i_clk) begin
        r_rd_zero <= rd_zero;
        case (i_ctrl.acc_op)
            ACC_CLR: r_acc <= '0;
            ACC_ADD: r_acc <= r_acc + ACC_W'(int_masked);
            ACC_SUB: r_acc <= r_acc - ACC_W'(int_masked);
            default: ;
        endcase
        if (i_ctrl.cur_ld) begin
            r_cur <= pix_rdata;
        end
    end

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_ctrl.mul_op)
            MUL_CNT: begin
                mul_a = MUL_A_W'(dx);
                mul_b = MUL_B_W'(dy);
            end
            MUL_CUR: begin
                mul_a = MUL_A_W'(r_cur);
                mul_b = MUL_B_W'(PCT_FULL);
            end
            MUL_LHS: begin
                mul_a = MUL_A_W'(r_cnt);
                mul_b = r_cur100;
            end
            MUL_RHS: begin
                mul_a = r_acc[SUM_W-1:0];
                mul_b = MUL_B_W'(keep_pct);
            end
            default: ;
        endcase
    end

    assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

    // product registers
    always_ff @(posedge i_clk) begin
        case (i_ctrl.mul_op)
            MUL_CNT: r_cnt    <= mul_p[CNT_W-1:0];
            MUL_CUR: r_cur100 <= mul_p[CUR_W-1:0];
            MUL_LHS: r_lhs    <= mul_p[LHS_W-1:0];
            MUL_RHS: r_rhs    <= mul_p[RHS_W-1:0];
            default: ;
        endcase
    end

    // a negative window sum wraps high, so it is dark unless nothing is kept
    assign bright = (r_acc[ACC_W-1] && (keep_pct != '0)) ? 1'b0
                  : (RHS_W'(r_lhs) > r_rhs);

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_ctrl.out_op != OUT_NONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((i_ctrl.out_op != OUT_NONE) && out_free) begin
            r_out_bright <= (i_ctrl.out_op == OUT_CMP) ? bright : 1'b0;
        end
    end

endmodule

FILE: hw/rtl/iiat_checker.sv
`timescale 1ns / 1ps
module iiat_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_bright
);

    // no result word right after reset
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // stalled result stays offered
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // stalled result keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_bright))
        else $error("result changed while stalled");

    // one word at a time: not ready in the cycle after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready right after accept");

    // no result can appear while the setup step and the step after it run, following an accept
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid) ##1 !$rose(i_out_valid))
        else $error("result too soon after accept");

endmodule

bind integral_image_adaptive_threshold iiat_checker u_iiat_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_pix.valid),
    .i_in_ready   (i_pix.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_out_bright (o_res.is_bright)
);

FILE: sim/integral_image_adaptive_threshold_tb.sv
`timescale 1ns / 1ps
module integral_image_adaptive_threshold_tb;
    import iiat_pkg::*;

    localparam logic CMD_LOAD     = 1'b0;
    localparam logic CMD_QUERY    = 1'b1;
    localparam int   ITEM_GOAL    = 1900;
    localparam int   IDLE_CYCLES  = 12;
    localparam int   DRAIN_CYCLES = 20;
    localparam int   DRAIN_LIMIT  = 20000;
    localparam int   TIMEOUT_NS   = 20_000_000;

    // image sizes for the first random phases: full rows, full columns, out-of-range codes
    localparam int EXT_W [5] = '{128, 1, 255, 0, 2};
    localparam int EXT_H [5] = '{1, 128, 2, 5, 255};

    typedef enum {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_BLOCKY} t_rx_mode;
    typedef enum {PIX_NOISE, PIX_BINARY, PIX_FLAT} t_pix_mode;

    typedef struct packed {
        logic             cmd;
        t_crd             x;
        t_crd             y;
        logic [PIX_W-1:0] value;
        logic             typed;
        logic             bright;
    } t_dir_row;

    // directed words: 4x3 image with one ignored load, then corner, dark and outside queries
    localparam int DIR_ROWS = 21;
    t_dir_row dir_tbl [DIR_ROWS] = '{
        '{CMD_LOAD,  7'd0,   7'd0,   8'd0,   1'b0, 1'b0},
        '{CMD_LOAD,  7'd1,   7'd0,   8'd255, 1'b0, 1'b0},
        '{CMD_LOAD,  7'd2,   7'd0,   8'd10,  1'b0, 1'b0},
        '{CMD_LOAD,  7'd3,   7'd0,   8'd200, 1'b0, 1'b0},
        '{CMD_LOAD,  7'd0,   7'd1,   8'd255, 1'b0, 1'b0},
        '{CMD_LOAD,  7'd1,   7'd1,   8'd255, 1'b0, 1'b0},
        '{CMD_LOAD,  7'd4,   7'd1,   8'd255, 1'b0, 1'b0},
        '{CMD_LOAD,  7'd2,   7'd1,   8'd0,   1'b0, 1'b0},
        '{CMD_LOAD,  7'd3,   7'd1,   8'd128, 1'b0, 1'b0},
        '{CMD_LOAD,  7'd0,   7'd2,   8'd1,   1'b0, 1'b0},
        '{CMD_LOAD,  7'd1,   7'd2,   8'd2,   1'b0, 1'b0},
        '{CMD_LOAD,  7'd2,   7'd2,   8'd254, 1'b0, 1'b0},
        '{CMD_LOAD,  7'd3,   7'd2,   8'd255, 1'b0, 1'b0},
        '{CMD_QUERY, 7'd0,   7'd0,   8'd255, 1'b1, 1'b0},
        '{CMD_QUERY, 7'd2,   7'd1,   8'd0,   1'b1, 1'b0},
        '{CMD_QUERY, 7'd3,   7'd2,   8'd0,   1'b0, 1'b0},
        '{CMD_QUERY, 7'd1,   7'd1,   8'd255, 1'b0, 1'b0},
        '{CMD_QUERY, 7'd3,   7'd0,   8'd0,   1'b0, 1'b0},
        '{CMD_QUERY, 7'd4,   7'd0,   8'd0,   1'b1, 1'b0},
        '{CMD_QUERY, 7'd0,   7'd3,   8'd255, 1'b1, 1'b0},
        '{CMD_QUERY, 7'd127, 7'd127, 8'd255, 1'b1, 1'b0}
    };

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_we    = 1'b0;
    logic [IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0] i_cfg_data  = '0;
    logic             px_valid    = 1'b0;
    logic             px_cmd      = 1'b0;
    t_crd             px_x        = '0;
    t_crd             px_y        = '0;
    logic [PIX_W-1:0] px_value    = '0;
    logic             rx_ready    = 1'b0;

    iiat_pix_if pix ();
    iiat_res_if res ();

    assign pix.valid       = px_valid;
    assign pix.cmd         = px_cmd;
    assign pix.pixel_x     = px_x;
    assign pix.pixel_y     = px_y;
    assign pix.pixel_value = px_value;
    assign res.ready       = rx_ready;

    integral_image_adaptive_threshold u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pix       (pix),
        .o_res       (res)
    );

    always #10 i_clk = ~i_clk;

    // predicted block state
    logic [CFG_W-1:0]   cfg_width  = RST_IMAGE_WIDTH;
    logic [CFG_W-1:0]   cfg_height = RST_IMAGE_HEIGHT;
    logic [CFG_W-1:0]   cfg_window = RST_WINDOW_SIZE;
    logic [PCT_W-1:0]   cfg_thresh = RST_THRESHOLD;
    logic [RSUM_W-1:0]  row_sum    = '0;
    logic [PIX_W-1:0]   pix_mem [STORE_DEPTH];
    logic [INTEG_W-1:0] int_mem [STORE_DEPTH];

    logic brightness_q [$];
    logic rx_expect;
    int   burst_left = 0;
    int   n_loads    = 0;
    int   n_queries  = 0;
    int   n_results  = 0;
    int   n_bright   = 0;
    int   n_cfg      = 0;
    int   n_err      = 0;

    function automatic int clamp_dim(input int v, input int hi);
        return (v < 1) ? 1 : ((v > hi) ? hi : v);
    endfunction

    function automatic int clamp_to(input int v, input int hi);
        return (v < 0) ? 0 : ((v > hi) ? hi : v);
    endfunction

    // integral entry, zero above or left of the image
    function automatic logic [31:0] integ_at(input int x, input int y);
        if (x < 0 || y < 0) return '0;
        return 32'(int_mem[y * MAX_WIDTH + x]);
    endfunction

    // updates the image state for one word, returns 1 when a result word follows
    function automatic bit predict_threshold(input logic cmd, input int x, input int y,
                                             input int v, output logic bright);
        int               wd, ht, half, x1, x2, y1, y2;
        logic [31:0]      sum_val;
        longint unsigned  cnt, cur, sum64, lhs, rhs;
        int unsigned      pct;
        wd = clamp_dim(cfg_width, MAX_WIDTH);
        ht = clamp_dim(cfg_height, MAX_HEIGHT);
        bright = 1'b0;
        if (cmd == CMD_LOAD) begin
            if (x >= wd || y >= ht) return 1'b0;
            if (x == 0) row_sum = '0;
            row_sum = row_sum + RSUM_W'(v);
            pix_mem[y * MAX_WIDTH + x] = PIX_W'(v);
            int_mem[y * MAX_WIDTH + x] = INTEG_W'(32'(row_sum) + integ_at(x, y - 1));
            n_loads++;
            return 1'b0;
        end
        n_queries++;
        if (x >= wd || y >= ht) return 1'b1;
        // clamped window and its box sum
        half = int'(cfg_window) / 2;
        x1 = clamp_to(x - half, wd - 1);
        x2 = clamp_to(x + half, wd - 1);
        y1 = clamp_to(y - half, ht - 1);
        y2 = clamp_to(y + half, ht - 1);
        cnt = longint'(x2 - x1) * longint'(y2 - y1);
        sum_val = integ_at(x2, y2) - integ_at(x2, y1 - 1)
                - integ_at(x1 - 1, y2) + integ_at(x1 - 1, y1 - 1);
        cur = pix_mem[y * MAX_WIDTH + x];
        sum64 = sum_val;
        pct = (cfg_thresh > PCT_FULL) ? PCT_FULL : cfg_thresh;
        lhs = PCT_FULL * cur * cnt;
        rhs = sum64 * (PCT_FULL - pct);
        bright = (lhs > rhs);
        return 1'b1;
    endfunction

    // result checker and receiver stall pattern
    int       rx_cycle = 0;
    t_rx_mode rx_mode  = RX_OPEN;

    always @(posedge i_clk) begin
        if (i_rst_n && res.valid && rx_ready) begin
            if (brightness_q.size() == 0) begin
                $error("unexpected result word: is_bright %0b", res.is_bright);
                n_err++;
            end else begin
                rx_expect = brightness_q.pop_front();
                if (res.is_bright !== rx_expect) begin
                    $error("is_bright mismatch: expected %0b, actual %0b",
                           rx_expect, res.is_bright);
                    n_err++;
                end
                n_results++;
                if (res.is_bright === 1'b1) n_bright++;
            end
        end
        rx_cycle++;
        if (rx_cycle % 150 == 0) rx_mode = t_rx_mode'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN:   rx_ready <= 1'b1;
            RX_RANDOM: rx_ready <= ($urandom_range(0, 3) != 0);
            RX_SPARSE: rx_ready <= (rx_cycle % 5 == 0);
            default:   rx_ready <= ((rx_cycle / 8) % 2 == 0);
        endcase
    end

    // one word on the pixel channel, sent in bursts with random gaps
    task automatic send_word(input logic cmd, input int x, input int y, input int v,
                             input logic typed, input logic typed_bright);
        int   gap;
        bit   has_res;
        logic bright;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                px_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 160)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        px_valid <= 1'b1;
        px_cmd   <= cmd;
        px_x     <= CRD_W'(x);
        px_y     <= CRD_W'(y);
        px_value <= PIX_W'(v);
        @(posedge i_clk);
        while (!pix.ready) @(posedge i_clk);
        has_res = predict_threshold(cmd, x, y, v, bright);
        if (has_res) brightness_q.push_back(typed ? typed_bright : bright);
    endtask

    // a word with coordinates outside the image in use, if any exist
    task automatic send_outside(input logic cmd);
        int wd, ht, x, y;
        wd = clamp_dim(cfg_width, MAX_WIDTH);
        ht = clamp_dim(cfg_height, MAX_HEIGHT);
        if (wd == MAX_WIDTH && ht == MAX_HEIGHT) return;
        if (ht == MAX_HEIGHT || (wd < MAX_WIDTH && $urandom_range(0, 1) == 1)) begin
            x = $urandom_range(wd, MAX_WIDTH - 1);
            y = $urandom_range(0, MAX_HEIGHT - 1);
        end else begin
            x = $urandom_range(0, MAX_WIDTH - 1);
            y = $urandom_range(ht, MAX_HEIGHT - 1);
        end
        send_word(cmd, x, y, $urandom_range(0, 255), 1'b0, 1'b0);
    endtask

    // raster scan of the whole image, sometimes abandoned and rescanned from an earlier or the current row
    task automatic load_image();
        int        wd, ht, x, y, cut, done, base, tmp;
        t_pix_mode mode;
        wd = clamp_dim(cfg_width, MAX_WIDTH);
        ht = clamp_dim(cfg_height, MAX_HEIGHT);
        mode = t_pix_mode'($urandom_range(0, 2));
        base = $urandom_range(0, 255);
        cut = (wd * ht > 1 && $urandom_range(0, 4) == 0) ? $urandom_range(1, wd * ht - 1) : -1;
        x = 0;
        y = 0;
        done = 0;
        while (y < ht) begin
            if ($urandom_range(0, 15) == 0)
                send_outside(($urandom_range(0, 1) == 0) ? CMD_LOAD : CMD_QUERY);
            case (mode)
                PIX_NOISE:  tmp = $urandom_range(0, 255);
                PIX_BINARY: tmp = ($urandom_range(0, 1) == 1) ? 255 : 0;
                default:    tmp = clamp_to(base - 3 + int'($urandom_range(0, 6)), 255);
            endcase
            send_word(CMD_LOAD, x, y, tmp, 1'b0, 1'b0);
            done++;
            if (done == cut) begin
                y = $urandom_range(0, y);
                x = 0;
            end else begin
                x++;
                if (x == wd) begin
                    x = 0;
                    y++;
                end
            end
        end
    endtask

    task automatic query_batch(input int n);
        int wd, ht;
        wd = clamp_dim(cfg_width, MAX_WIDTH);
        ht = clamp_dim(cfg_height, MAX_HEIGHT);
        repeat (n) begin
            if ($urandom_range(0, 9) == 0)
                send_outside(CMD_QUERY);
            else
                send_word(CMD_QUERY, $urandom_range(0, wd - 1), $urandom_range(0, ht - 1),
                          $urandom_range(0, 255), 1'b0, 1'b0);
        end
    endtask

    // let every word finish before touching registers
    task automatic wait_idle();
        px_valid <= 1'b0;
        burst_left = 0;
        while (brightness_q.size() != 0) @(posedge i_clk);
        repeat (IDLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input int val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_W'(val);
        @(posedge i_clk);
        case (idx)
            CFG_IMAGE_WIDTH:  cfg_width  = CFG_W'(val);
            CFG_IMAGE_HEIGHT: cfg_height = CFG_W'(val);
            CFG_WINDOW_SIZE:  cfg_window = CFG_W'(val);
            CFG_THRESHOLD:    cfg_thresh = PCT_W'(val);
        endcase
        n_cfg++;
    endtask

    // negative value leaves a register as it is
    task automatic set_regs(input int w, input int h, input int ws, input int t);
        if (w >= 0)  write_reg(CFG_IMAGE_WIDTH, w);
        if (h >= 0)  write_reg(CFG_IMAGE_HEIGHT, h);
        if (ws >= 0) write_reg(CFG_WINDOW_SIZE, ws);
        if (t >= 0)  write_reg(CFG_THRESHOLD, t);
        i_cfg_we <= 1'b0;
    endtask

    function automatic int pick_window();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 128;
            2:       return 255;
            3:       return $urandom_range(1, 4);
            default: return $urandom_range(0, 24);
        endcase
    endfunction

    function automatic int pick_threshold();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 100;
            2:       return 127;
            3:       return 15;
            default: return $urandom_range(0, 100);
        endcase
    endfunction

    // main stimulus
    initial begin
        int phase, rounds, w, h, guard;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed words on a small image
        set_regs(4, 3, 2, 0);
        foreach (dir_tbl[i])
            send_word(dir_tbl[i].cmd, dir_tbl[i].x, dir_tbl[i].y, dir_tbl[i].value,
                      dir_tbl[i].typed, dir_tbl[i].bright);

        // random phases: new image, then query rounds under changing window and threshold
        for (phase = 0; n_loads + n_queries < ITEM_GOAL; phase++) begin
            if (phase < 5) begin
                w = EXT_W[phase];
                h = EXT_H[phase];
            end else if ($urandom_range(0, 7) == 0) begin
                w = $urandom_range(13, 48);
                h = $urandom_range(1, 4);
            end else begin
                w = $urandom_range(1, 12);
                h = $urandom_range(1, 12);
            end
            wait_idle();
            set_regs(w, h, pick_window(), pick_threshold());
            load_image();
            rounds = $urandom_range(1, 3);
            for (int r = 0; r < rounds; r++) begin
                if (r > 0) begin
                    wait_idle();
                    set_regs(-1, -1, pick_window(), pick_threshold());
                end
                query_batch($urandom_range(4, 16));
            end
        end

        // drain outstanding result words
        px_valid <= 1'b0;
        guard = 0;
        while (brightness_q.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        if (brightness_q.size() != 0) begin
            $error("%0d expected result words never arrived", brightness_q.size());
            n_err++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d pixel loads and %0d queries across %0d register writes",
                 n_loads, n_queries, n_cfg);
        $display("%0d of %0d result words came back bright", n_bright, n_results);
        if (n_err == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // run time limit
    initial begin
        #(TIMEOUT_NS);
        $display("TB_ERROR");
        $finish;
    end

endmodule
